// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers; all of them can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ACL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// The condition must never be true at a clock edge outside reset.
`define ACL_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ACL_ASSERT(lbl, prop)
`define ACL_ASSERT_NEVER(lbl, cond)

`endif

`endif

// File: rtl/core/acl_pkg.sv
// ----------------------------------------------------------------------------
// acl_pkg
// Types, constants and the final line classification shared by the classifier.
// ----------------------------------------------------------------------------
package acl_pkg;

  typedef logic [35:0] acc_t;

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  localparam acc_t DIST_MAX  = 36'd4294967295;
  localparam acc_t AO_MIN    = 36'd320;
  localparam acc_t AO_MAX    = 36'd2400;
  localparam acc_t SWEEP_MAX = 36'd20;
  localparam acc_t SPEED_INT = 36'd6;
  localparam logic [6:0] SPEED_MIN_FRAC = 7'd10;
  localparam logic [4:0] NAME_MIN_LEN = 5'd5;
  localparam logic [4:0] NAME_MAX_LEN = 5'd21;

  typedef enum logic [3:0] {
    KIND_INVALID = 4'd0,
    KIND_UNSUPP  = 4'd1,
    KIND_STOP    = 4'd2,
    KIND_HELP    = 4'd3,
    KIND_VERSION = 4'd4,
    KIND_STATUS  = 4'd5,
    KIND_ERROR   = 4'd6,
    KIND_FORMAL  = 4'd7,
    KIND_TEST    = 4'd8
  } kind_e;

  typedef struct packed {
    logic       outcome;
    kind_e      kind;
    logic [7:0] letter;
  } result_t;

  typedef struct packed {
    logic store;
    logic discard_set;
    logic flush;
    logic scan_start;
    logic scan_rd;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_cr;
    logic is_lf;
    logic len_zero;
    logic len_full;
    logic discard;
    logic rd_last;
  } dp_stat_t;

  // First five text characters (first one in the top byte), the saturated
  // text length and the verdict of the argument parser.
  typedef struct packed {
    logic [39:0] text;
    logic [4:0]  tlen;
    logic        num_ok;
  } scan_stat_t;

  // Characters past the end of the text read as zero, so a word of up to four
  // characters matches exactly when the zero-padded text equals it.
  function automatic result_t classify(logic [39:0] t, logic [4:0] n, logic num_ok);
    result_t    r;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    logic       tw;
    c0 = t[39:32];
    c1 = t[31:24];
    c2 = t[23:16];
    c3 = t[15:8];
    r.outcome = 1'b0;
    r.kind    = KIND_INVALID;
    r.letter  = 8'h00;
    tw = (t == {"SC", 24'h0}) || (t == {"C", 32'h0}) || (t == {"D", 32'h0}) ||
         (t == {"E", 32'h0}) || (t == {"F", 32'h0}) || (t == {"H", 32'h0}) ||
         (t == {"J", 32'h0}) || (t == {"L", 32'h0}) || (t == {"M", 32'h0}) ||
         (t == {"N", 32'h0}) || (t == {"X", 32'h0}) || (t == {"T0", 24'h0}) ||
         (t == {"T1", 24'h0}) || (t == {"T2", 24'h0}) || (t == {"TA", 24'h0}) ||
         (t == {"TS", 24'h0}) || (t == {"TR", 24'h0}) || (t == {"TV", 24'h0}) ||
         (t == {"TP", 24'h0}) || (t == {"TU", 24'h0}) || (t == {"YM", 24'h0}) ||
         (t == {"YE", 24'h0}) || (t == {"YS", 24'h0}) || (t == {"YC", 24'h0}) ||
         (t == {"YT", 24'h0});
    if (n == 5'd0) begin
      r.kind = KIND_INVALID;
    end else if (t == {"STOP", 8'h0}) begin
      r.kind = KIND_STOP;
    end else if (t == {"HELP", 8'h0}) begin
      r.kind = KIND_HELP;
    end else if (t == {"VER?", 8'h0}) begin
      r.kind = KIND_VERSION;
    end else if (n == 5'd5 && t == "STAT?") begin
      r.kind = KIND_STATUS;
    end else if (t == {"ERR?", 8'h0}) begin
      r.kind = KIND_ERROR;
    end else if (c0 == "I" || c0 == "G" || c0 == "K" || c0 == "R" ||
                 c0 == "W" || c0 == "O" || c0 == "P" || c0 == "Q") begin
      if (n == 5'd1) begin
        r.kind   = KIND_FORMAL;
        r.letter = c0;
      end
    end else if (c0 == "A" && c1 == "O") begin
      r.kind = (t == {"AOS", 16'h0} || num_ok) ? KIND_TEST : KIND_INVALID;
    end else if (c0 == "A") begin
      r.kind = (t == {"A0", 24'h0} || num_ok) ? KIND_TEST : KIND_INVALID;
    end else if (c0 == "B") begin
      r.kind = num_ok ? KIND_TEST : KIND_INVALID;
    end else if (c0 == "S" && c1 == "P") begin
      r.kind = (t == {"SPS", 16'h0} || t == {"SPR", 16'h0} || t == {"SPC", 16'h0} ||
                (c2 == "N" && c3 == "=" && n >= NAME_MIN_LEN && n <= NAME_MAX_LEN)) ?
               KIND_TEST : KIND_INVALID;
    end else if (tw) begin
      r.kind = KIND_TEST;
    end else if (c0 == "C" || c0 == "D" || c0 == "E" || c0 == "F" || c0 == "H" ||
                 c0 == "J" || c0 == "L" || c0 == "M" || c0 == "N" || c0 == "T" ||
                 c0 == "Y" || c0 == "X" || c0 == "S") begin
      r.kind = KIND_INVALID;
    end else begin
      r.kind = KIND_UNSUPP;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/acl_rx_if.sv
// ----------------------------------------------------------------------------
// acl_rx_if
// Byte channel into the classifier.
// ----------------------------------------------------------------------------
interface acl_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/acl_res_if.sv
// ----------------------------------------------------------------------------
// acl_res_if
// Result channel out of the classifier.
// ----------------------------------------------------------------------------
interface acl_res_if;
  logic       valid;
  logic       ready;
  logic       outcome;
  logic [3:0] command_kind;
  logic [7:0] formal_letter;

  modport source (output valid, output outcome, output command_kind,
                  output formal_letter, input ready);
  modport sink (input valid, input outcome, input command_kind,
                input formal_letter, output ready);
endinterface

// File: rtl/core/acl_scan.sv
// ----------------------------------------------------------------------------
// acl_scan
// Character-serial recognizer that walks the stored line once.
// ----------------------------------------------------------------------------
module acl_scan #(
  parameter int unsigned LW = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    init_i,
  input  logic                    feed_i,
  input  logic [7:0]              char_i,
  output acl_pkg::scan_stat_t     stat_o
);

  // Grammar states of the argument parser.
  localparam logic [3:0] G_IDLE = 4'd0;
  localparam logic [3:0] G_FAIL = 4'd1;
  localparam logic [3:0] G_END  = 4'd2;
  localparam logic [3:0] G_U1   = 4'd3;
  localparam logic [3:0] G_ONE  = 4'd4;
  localparam logic [3:0] G_U2   = 4'd5;
  localparam logic [3:0] G_SL   = 4'd6;
  localparam logic [3:0] G_DD   = 4'd7;
  localparam logic [3:0] G_SD   = 4'd8;

  // Command forms.
  localparam logic [2:0] M_A   = 3'd0;
  localparam logic [2:0] M_AO  = 3'd1;
  localparam logic [2:0] M_B   = 3'd2;
  localparam logic [2:0] M_BE  = 3'd3;
  localparam logic [2:0] M_BJ  = 3'd4;
  localparam logic [2:0] M_BJP = 3'd5;

  logic [4:0][7:0] text_q, text_d;
  logic [LW-1:0]   tlen_q, tlen_d;
  logic            ended_q, ended_d;
  logic [3:0]      gs_q, gs_d, gs_e;
  logic [2:0]      mode_q, mode_d, md_e;
  acl_pkg::acc_t   acc_q, acc_d, acc_b, acc_nx, hi_sel, lo_sel;
  logic            over_q, over_d, over_b, over_nx;
  logic            seen_q, seen_d, seen_b;
  logic            infrac_q, infrac_d, infrac_b;
  logic [1:0]      nf_q, nf_d, nf_b;
  logic [3:0]      f1_q, f1_d, f1_b, f2_q, f2_d, f2_b;
  logic            rest_q, rest_d, rest_b;
  logic            start, num_clr, is_dig;
  logic [3:0]      dig;
  logic [6:0]      fv;
  logic            uint_ok, dist_ok, spd_ok, num_ok;

  always_comb begin
    is_dig = (char_i >= "0") && (char_i <= "9");
    dig    = 4'(char_i - 8'h30);

    // A number starts at a fixed position that the prefix decides.
    start = 1'b0;
    gs_e  = gs_q;
    md_e  = mode_q;
    if (feed_i && !ended_q && char_i != 8'h00 && gs_q == G_IDLE) begin
      if (tlen_q == LW'(1) && text_q[0] == "B" && char_i != "J" && char_i != "E") begin
        start = 1'b1; gs_e = G_U1; md_e = M_B;
      end else if (tlen_q == LW'(2) && text_q[0] == "A" && text_q[1] == "O") begin
        start = 1'b1; gs_e = G_U1; md_e = M_AO;
      end else if (tlen_q == LW'(2) && text_q[0] == "A" &&
                   (text_q[1] == "+" || text_q[1] == "-")) begin
        start = 1'b1; gs_e = G_U1; md_e = M_A;
      end else if (tlen_q == LW'(2) && text_q[0] == "B" && text_q[1] == "E") begin
        start = 1'b1; gs_e = G_U1; md_e = M_BE;
      end else if (tlen_q == LW'(3) && text_q[0] == "B" && text_q[1] == "J" &&
                   text_q[2] == "P") begin
        start = 1'b1; gs_e = G_DD; md_e = M_BJP;
      end else if (tlen_q == LW'(3) && text_q[0] == "B" && text_q[1] == "J" &&
                   (text_q[2] == "+" || text_q[2] == "-")) begin
        start = 1'b1; gs_e = G_DD; md_e = M_BJ;
      end
    end

    acc_b    = start ? '0 : acc_q;
    over_b   = start ? 1'b0 : over_q;
    seen_b   = start ? 1'b0 : seen_q;
    infrac_b = start ? 1'b0 : infrac_q;
    nf_b     = start ? 2'd0 : nf_q;
    f1_b     = start ? 4'd0 : f1_q;
    f2_b     = start ? 4'd0 : f2_q;
    rest_b   = start ? 1'b0 : rest_q;

    // Fraction in hundredths.
    case (nf_b)
      2'd0:    fv = 7'd0;
      2'd1:    fv = 7'(f1_b) * 7'd10;
      default: fv = 7'(f1_b) * 7'd10 + 7'(f2_b);
    endcase

    hi_sel = (gs_e == G_U1 && md_e == M_AO) ? acl_pkg::AO_MAX :
             (gs_e == G_U2) ? acl_pkg::SWEEP_MAX : acl_pkg::DIST_MAX;
    lo_sel = (gs_e == G_U1 && md_e == M_AO) ? acl_pkg::AO_MIN : acl_pkg::acc_t'(1);

    acc_nx  = (acc_b << 3) + (acc_b << 1) + acl_pkg::acc_t'(dig);
    over_nx = over_b || (acc_nx > hi_sel);

    uint_ok = seen_b && !over_b && (acc_b >= lo_sel);
    dist_ok = seen_b && !over_b &&
              !(acc_b == acl_pkg::DIST_MAX && (fv != 7'd0 || rest_b)) &&
              (md_e == M_BJP || acc_b != '0 || fv != 7'd0 || rest_b);
    spd_ok  = seen_b && !over_b && (acc_b <= acl_pkg::SPEED_INT) &&
              (acc_b != '0 || fv >= acl_pkg::SPEED_MIN_FRAC) &&
              (acc_b < acl_pkg::SPEED_INT || (fv == 7'd0 && !rest_b));

    case (gs_q)
      G_U1, G_U2: num_ok = uint_ok;
      G_END:      num_ok = 1'b1;
      G_DD:       num_ok = dist_ok;
      G_SD:       num_ok = spd_ok;
      default:    num_ok = 1'b0;
    endcase

    text_d   = text_q;
    tlen_d   = tlen_q;
    ended_d  = ended_q;
    gs_d     = gs_q;
    mode_d   = mode_q;
    acc_d    = acc_q;
    over_d   = over_q;
    seen_d   = seen_q;
    infrac_d = infrac_q;
    nf_d     = nf_q;
    f1_d     = f1_q;
    f2_d     = f2_q;
    rest_d   = rest_q;
    num_clr  = 1'b0;

    if (init_i) begin
      text_d  = '0;
      tlen_d  = '0;
      ended_d = 1'b0;
      gs_d    = G_IDLE;
      mode_d  = M_A;
      num_clr = 1'b1;
    end else if (feed_i && !ended_q) begin
      if (char_i == 8'h00) begin
        ended_d = 1'b1;
      end else begin
        tlen_d = tlen_q + LW'(1);
        if (tlen_q < LW'(5)) begin
          text_d[tlen_q[2:0]] = char_i;
        end
        gs_d     = gs_e;
        mode_d   = md_e;
        acc_d    = acc_b;
        over_d   = over_b;
        seen_d   = seen_b;
        infrac_d = infrac_b;
        nf_d     = nf_b;
        f1_d     = f1_b;
        f2_d     = f2_b;
        rest_d   = rest_b;
        case (gs_e)
          G_U1, G_U2: begin
            if (is_dig) begin
              acc_d  = acc_nx;
              over_d = over_nx;
              seen_d = 1'b1;
            end else if (!uint_ok) begin
              gs_d = G_FAIL;
            end else if (gs_e == G_U2) begin
              gs_d = (char_i == ",") ? G_SL : G_FAIL;
            end else if (md_e == M_B && char_i == "S") begin
              gs_d = G_END;
            end else if (md_e == M_B && char_i == ",") begin
              gs_d = G_ONE;
            end else if (md_e == M_BE && char_i == "S") begin
              gs_d = G_END;
            end else if (md_e == M_BE && char_i == ",") begin
              gs_d    = G_SD;
              num_clr = 1'b1;
            end else begin
              gs_d = G_FAIL;
            end
          end
          G_ONE: gs_d = (char_i == "1") ? G_END : G_FAIL;
          G_SL:  gs_d = (char_i == "S" || char_i == "1") ? G_END : G_FAIL;
          G_DD, G_SD: begin
            if (is_dig && !infrac_b) begin
              acc_d  = acc_nx;
              over_d = over_nx;
              seen_d = 1'b1;
            end else if (is_dig) begin
              seen_d = 1'b1;
              if (nf_b == 2'd0) begin
                f1_d = dig;
                nf_d = 2'd1;
              end else if (nf_b == 2'd1) begin
                f2_d = dig;
                nf_d = 2'd2;
              end else if (dig != 4'd0) begin
                rest_d = 1'b1;
              end
            end else if (char_i == "." && !infrac_b) begin
              infrac_d = 1'b1;
            end else if (!((gs_e == G_DD) ? dist_ok : spd_ok)) begin
              gs_d = G_FAIL;
            end else if (gs_e == G_DD && char_i == ",") begin
              gs_d    = G_SD;
              num_clr = 1'b1;
            end else if (gs_e == G_SD && md_e == M_BE && char_i == ",") begin
              gs_d    = G_U2;
              num_clr = 1'b1;
            end else begin
              gs_d = G_FAIL;
            end
          end
          G_END:   gs_d = G_FAIL;
          default: gs_d = gs_e;
        endcase
      end
    end

    if (num_clr) begin
      acc_d    = '0;
      over_d   = 1'b0;
      seen_d   = 1'b0;
      infrac_d = 1'b0;
      nf_d     = 2'd0;
      f1_d     = 4'd0;
      f2_d     = 4'd0;
      rest_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlen_q  <= '0;
      ended_q <= 1'b0;
      gs_q    <= G_IDLE;
      mode_q  <= M_A;
    end else begin
      tlen_q  <= tlen_d;
      ended_q <= ended_d;
      gs_q    <= gs_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    text_q   <= text_d;
    acc_q    <= acc_d;
    over_q   <= over_d;
    seen_q   <= seen_d;
    infrac_q <= infrac_d;
    nf_q     <= nf_d;
    f1_q     <= f1_d;
    f2_q     <= f2_d;
    rest_q   <= rest_d;
  end

  assign stat_o.text   = {text_q[0], text_q[1], text_q[2], text_q[3], text_q[4]};
  assign stat_o.tlen   = (32'(tlen_q) > 32'd31) ? 5'd31 : 5'(tlen_q);
  assign stat_o.num_ok = num_ok;

endmodule

// File: rtl/core/acl_dp.sv
// ----------------------------------------------------------------------------
// acl_dp
// Datapath: line store, length and discard state, scan feed and result register.
// ----------------------------------------------------------------------------
module acl_dp #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            rx_byte_i,
  input  acl_pkg::ctrl_cmd_t    cmd_i,
  output acl_pkg::dp_stat_t     stat_o,
  output acl_pkg::result_t      res_o
);

  localparam int unsigned LW    = $clog2(LINE_CAPACITY);
  localparam int unsigned DEPTH = LINE_CAPACITY - 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [7:0]          line_mem [DEPTH];
  logic [7:0]          rdata_q;
  logic [LW-1:0]       len_q;
  logic [AW-1:0]       addr_q;
  logic                discard_q;
  logic                feed_q;
  acl_pkg::result_t    res_q;
  acl_pkg::scan_stat_t scan_stat;

  // Line store: one write port for received bytes, one read port for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      line_mem[len_q[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.scan_rd) begin
      rdata_q <= line_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      addr_q    <= '0;
      discard_q <= 1'b0;
      feed_q    <= 1'b0;
    end else begin
      feed_q <= cmd_i.scan_rd;
      if (cmd_i.store) begin
        len_q <= len_q + LW'(1);
      end else if (cmd_i.flush || cmd_i.finish) begin
        len_q <= '0;
      end
      if (cmd_i.discard_set) begin
        discard_q <= 1'b1;
      end else if (cmd_i.flush) begin
        discard_q <= 1'b0;
      end
      if (cmd_i.scan_start) begin
        addr_q <= '0;
      end else if (cmd_i.scan_rd) begin
        addr_q <= addr_q + AW'(1);
      end
    end
  end

  acl_scan #(
    .LW (LW)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_i (cmd_i.scan_start),
    .feed_i (feed_q),
    .char_i (rdata_q),
    .stat_o (scan_stat)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.flush) begin
      res_q.outcome <= 1'b1;
      res_q.kind    <= acl_pkg::KIND_INVALID;
      res_q.letter  <= 8'h00;
    end else if (cmd_i.finish) begin
      res_q <= acl_pkg::classify(scan_stat.text, scan_stat.tlen, scan_stat.num_ok);
    end
  end

  assign stat_o.is_cr    = (rx_byte_i == acl_pkg::CH_CR);
  assign stat_o.is_lf    = (rx_byte_i == acl_pkg::CH_LF);
  assign stat_o.len_zero = (len_q == '0);
  assign stat_o.len_full = (len_q == LW'(DEPTH));
  assign stat_o.discard  = discard_q;
  assign stat_o.rd_last  = ((LW + 1)'(addr_q) + (LW + 1)'(1)) == (LW + 1)'(len_q);
  assign res_o           = res_q;

endmodule

// File: rtl/core/acl_ctrl.sv
// ----------------------------------------------------------------------------
// acl_ctrl
// Controller: input and output handshakes and the line scan sequence.
// ----------------------------------------------------------------------------
module acl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  acl_pkg::dp_stat_t  stat_i,
  output acl_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    // A line feed may produce a result, so it waits for the output register.
    in_ready_o = (state_q == ST_IDLE) && !(stat_i.is_lf && out_valid_q);
    accept     = in_valid_i && in_ready_o;
    case (state_q)
      ST_IDLE: begin
        if (accept && !stat_i.is_cr) begin
          if (stat_i.is_lf) begin
            if (stat_i.discard) begin
              cmd_o.flush = 1'b1;
            end else if (!stat_i.len_zero) begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
          end else if (!stat_i.discard) begin
            if (stat_i.len_full) begin
              cmd_o.discard_set = 1'b1;
            end else begin
              cmd_o.store = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.rd_last) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: state_d = ST_FIN;
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.flush || cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/ascii_command_line_classifier.sv
// ----------------------------------------------------------------------------
// ascii_command_line_classifier
// Collects a serial command line byte by byte and classifies it at line feed.
// ----------------------------------------------------------------------------
// Every byte other than a line feed is accepted while idle: carriage returns
// are dropped, other bytes go into a line store of LINE_CAPACITY-1 entries, and
// once the store is full the rest of the line is thrown away and the closing
// line feed reports the line as too long. A line feed that closes a non-empty
// line of N stored bytes starts a scan that reads the store through its single
// read port, one byte per cycle, into a character-serial recognizer; a tail
// state and a finish state then classify the line into the result register; no
// byte is accepted meanwhile. A line feed that closes an empty line gives no
// item. A line feed is held off while an earlier result item still waits in the
// output register; all other bytes keep flowing. The store needs no clearing
// after reset, since only bytes written in the current line are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ascii_command_line_classifier #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  acl_rx_if.sink     rx_i,
  acl_res_if.source  res_o
);

  acl_pkg::ctrl_cmd_t cmd;
  acl_pkg::dp_stat_t  stat;
  acl_pkg::result_t   res;

  // The controller sequences storing, discarding and the scan; it also owns
  // both handshakes, so the datapath never sees valid or ready.
  acl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_ready_o  (rx_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the line store, the length and discard state, the
  // recognizer and the result register.
  acl_dp #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (rx_i.rx_byte),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .res_o     (res)
  );

  assign res_o.outcome       = res.outcome;
  assign res_o.command_kind  = res.kind;
  assign res_o.formal_letter = res.letter;

  // No byte can slip in while the store is being read out.
  `ACL_ASSERT(a_scan_blocks_input, cmd.scan_rd |-> !rx_i.ready)
  // A started scan always reads at least one stored byte.
  `ACL_ASSERT(a_scan_reads_next, cmd.scan_start |=> cmd.scan_rd)
  // A classified line never overwrites a result that was not yet taken.
  `ACL_ASSERT(a_finish_output_free, cmd.finish |-> !res_o.valid)
  // Bytes of a line that overflowed are never stored.
  `ACL_ASSERT_NEVER(a_no_store_in_discard, stat.discard && cmd.store)

endmodule
